// ----- hdl/etab_pkg.sv -----
// Package for the entity table engine: table size, function and status codes,
// request/response payload structs and controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package etab_pkg;

   localparam int DEPTH        = 16;
   localparam int SLOT_W       = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int SLOT_FIELD_W = 4;

   localparam logic [2:0] FUNC_CREATE    = 3'd0;
   localparam logic [2:0] FUNC_FIND_ID   = 3'd1;
   localparam logic [2:0] FUNC_FIND_SOCK = 3'd2;
   localparam logic [2:0] FUNC_UPDATE    = 3'd3;
   localparam logic [2:0] FUNC_KILL      = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NO_MATCH = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic [7:0]         kind;
      logic [31:0]        owner;
      logic [31:0]        handle;
      logic [31:0]        key_id;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_vx;
      logic signed [31:0] new_vy;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [31:0]             rec_id;
      logic [7:0]              rec_kind;
      logic [31:0]             rec_owner;
      logic [31:0]             rec_handle;
      logic signed [31:0]      rec_x;
      logic signed [31:0]      rec_y;
      logic signed [31:0]      rec_vx;
      logic signed [31:0]      rec_vy;
   } rsp_type;

   // one table entry, minus motion and live flag
   typedef struct packed {
      logic [31:0] id;
      logic [7:0]  kind;
      logic [31:0] owner;
      logic [31:0] handle;
   } rec_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } mot_type;

   typedef struct packed {
      logic       cap_req;
      logic       scan_start;
      logic       scan_run;
      logic       create;
      logic       hit;
      logic       fail;
      logic [1:0] fail_code;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       full;
      logic       hit;
      logic       exhausted;
      logic       out_busy;
   } sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN
   } state_type;

endpackage

// ----- hdl/etab_ctrl.sv -----
// Controller for the entity table engine: sequences request capture, decode,
// the slot scan and the result load. Depends on etab_pkg.
`timescale 1ns / 1ps

module etab_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  etab_pkg::sts_type sts,
   output etab_pkg::cmd_type cmd
);
   import etab_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.func == FUNC_CREATE || sts.func > FUNC_KILL) begin
               if (!sts.out_busy) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((sts.hit || sts.exhausted) && !sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.cap_req    = 1'b1;
               cmd.scan_start = 1'b1;
            end
         end
         ST_DECODE: begin
            if (!sts.out_busy) begin
               if (sts.func == FUNC_CREATE) begin
                  if (sts.full) begin
                     cmd.fail      = 1'b1;
                     cmd.fail_code = STAT_FULL;
                  end else begin
                     cmd.create = 1'b1;
                  end
               end else if (sts.func > FUNC_KILL) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = STAT_NO_MATCH;
               end
            end
         end
         ST_SCAN: begin
            // pipeline freezes on a hit or at the end so the read data holds
            if (sts.hit) begin
               cmd.hit = !sts.out_busy;
            end else if (sts.exhausted) begin
               cmd.fail      = !sts.out_busy;
               cmd.fail_code = STAT_NO_MATCH;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- hdl/etab_dp.sv -----
// Datapath for the entity table engine: record and motion memories, live
// flags, fill count, id counter, scan pipeline and result register.
// Depends on etab_pkg.
`timescale 1ns / 1ps

module etab_dp (
   input  logic              clock,
   input  logic              reset,
   input  etab_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output etab_pkg::rsp_type rsp_data,
   input  etab_pkg::cmd_type cmd,
   output etab_pkg::sts_type sts
);
   import etab_pkg::*;

   rec_type rec_mem [DEPTH];
   mot_type mot_mem [DEPTH];

   req_type            req_ff;
   logic [CNT_W-1:0]   used_ff;
   logic [31:0]        next_id_ff;
   logic [DEPTH-1:0]   live_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   cmp_ptr_ff;
   logic               cmp_on_ff;
   rec_type            rec_q_ff;
   mot_type            mot_q_ff;
   logic               rsp_vld_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [SLOT_W-1:0]  rd_addr;
   logic [SLOT_W-1:0]  new_idx;
   logic [SLOT_W-1:0]  cmp_idx;
   logic               ptr_in_range;
   logic [31:0]        key;
   logic [31:0]        cand;
   logic               match;
   logic               mot_we;
   logic [SLOT_W-1:0]  mot_addr;
   mot_type            mot_wdata;
   mot_type            mot_new;
   logic               load;

   assign rd_addr      = ptr_ff[SLOT_W-1:0];
   assign new_idx      = used_ff[SLOT_W-1:0];
   assign cmp_idx      = cmp_ptr_ff[SLOT_W-1:0];
   assign ptr_in_range = ptr_ff < used_ff;

   assign key   = (req_ff.func == FUNC_FIND_SOCK) ? req_ff.handle : req_ff.key_id;
   assign cand  = (req_ff.func == FUNC_FIND_SOCK) ? rec_q_ff.handle : rec_q_ff.id;
   assign match = cmp_on_ff && live_ff[cmp_idx] && (cand == key);

   assign mot_new = '{x: req_ff.new_x, y: req_ff.new_y, vx: req_ff.new_vx, vy: req_ff.new_vy};

   assign sts.func      = req_ff.func;
   assign sts.full      = (used_ff == CNT_W'(DEPTH));
   assign sts.hit       = match;
   assign sts.exhausted = !cmp_on_ff && !ptr_in_range;
   assign sts.out_busy  = rsp_vld_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         req_ff <= req_data;
      end
   end

   // scan: address issued from ptr, compare on the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         cmp_on_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         ptr_ff    <= '0;
         cmp_on_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         if (ptr_in_range) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end
         cmp_on_ff <= ptr_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_run) begin
         cmp_ptr_ff <= ptr_ff;
         rec_q_ff   <= rec_mem[rd_addr];
         mot_q_ff   <= mot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.create) begin
         rec_mem[new_idx] <= '{id: next_id_ff, kind: req_ff.kind,
                               owner: req_ff.owner, handle: req_ff.handle};
      end
   end

   assign mot_we    = cmd.create || (cmd.hit && req_ff.func == FUNC_UPDATE);
   assign mot_addr  = cmd.create ? new_idx : cmp_idx;
   assign mot_wdata = cmd.create ? mot_type'('0) : mot_new;

   always_ff @(posedge clock) begin
      if (mot_we) begin
         mot_mem[mot_addr] <= mot_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         next_id_ff <= 32'd1;
         live_ff    <= '0;
      end else if (cmd.create) begin
         used_ff          <= used_ff + CNT_W'(1);
         next_id_ff       <= next_id_ff + 32'd1;
         live_ff[new_idx] <= 1'b1;
      end else if (cmd.hit && req_ff.func == FUNC_KILL) begin
         live_ff[cmp_idx] <= 1'b0;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.create) begin
         rsp_in.status     = STAT_OK;
         rsp_in.slot       = SLOT_FIELD_W'(new_idx);
         rsp_in.rec_id     = next_id_ff;
         rsp_in.rec_kind   = req_ff.kind;
         rsp_in.rec_owner  = req_ff.owner;
         rsp_in.rec_handle = req_ff.handle;
      end else if (cmd.hit) begin
         rsp_in.status     = STAT_OK;
         rsp_in.slot       = SLOT_FIELD_W'(cmp_idx);
         rsp_in.rec_id     = rec_q_ff.id;
         rsp_in.rec_kind   = rec_q_ff.kind;
         rsp_in.rec_owner  = rec_q_ff.owner;
         rsp_in.rec_handle = rec_q_ff.handle;
         if (req_ff.func == FUNC_UPDATE) begin
            rsp_in.rec_x  = mot_new.x;
            rsp_in.rec_y  = mot_new.y;
            rsp_in.rec_vx = mot_new.vx;
            rsp_in.rec_vy = mot_new.vy;
         end else begin
            rsp_in.rec_x  = mot_q_ff.x;
            rsp_in.rec_y  = mot_q_ff.y;
            rsp_in.rec_vx = mot_q_ff.vx;
            rsp_in.rec_vy = mot_q_ff.vy;
         end
      end else begin
         rsp_in.status = cmd.fail_code;
      end
   end

   assign load = cmd.create || cmd.hit || cmd.fail;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.create, cmd.hit, cmd.fail}))
      else $error("more than one finishing action in a cycle");

   a_create_room: assert property (@(posedge clock) disable iff (reset)
      cmd.create |-> used_ff < CNT_W'(DEPTH))
      else $error("create issued on a full table");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      cmd.create |=> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("fill count did not advance on create");

   a_live_filled: assert property (@(posedge clock) disable iff (reset)
      (live_ff >> used_ff) == '0)
      else $error("live flag set beyond the filled slots");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load && sts.out_busy |-> 1'b0)
      else $error("result loaded over one still waiting");

endmodule

// ----- hdl/entity_table_engine_unit.sv -----
// Top level of the entity table engine: controller plus datapath.
// Depends on etab_pkg, etab_ctrl and etab_dp.
`timescale 1ns / 1ps

// Entity table engine. One request at a time: req_stall is low only while the
// block is idle. Create and invalid-function requests load their result from
// the decode state, which waits while an earlier result is still held, and
// then return to idle for the next request. Find, update and kill scan the
// filled slots in order through the record memory, one slot per cycle, with
// the read data registered before the compare. The scan stops at the first
// hit, or after the last filled slot on a miss, and loads the result once the
// output register is free; the block then returns to idle for the next
// request. The result sits in an output register; the block accepts the next
// request while it waits, but holds the following result until that one is
// taken.
// Reset empties the table at once; no clearing pass is needed.
module entity_table_engine_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  etab_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output etab_pkg::rsp_type rsp_data
);
   import etab_pkg::*;

   cmd_type cmd;
   sts_type sts;

   etab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   etab_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
